// ===== rtl/ps2mc_pkg.sv =====
`default_nettype none
package ps2mc_pkg;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W = 8;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  // Register map of the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_HOME  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HOME  = 8'd3;

  localparam coord_t X_LIMIT_RST = 10'd319;
  localparam coord_t Y_LIMIT_RST = 10'd239;
  localparam coord_t X_HOME_RST  = 10'd160;
  localparam coord_t Y_HOME_RST  = 10'd120;

  // Status byte bit that is always set in a valid first byte
  localparam int unsigned SYNC_BIT = 3;

  // A completed packet, handed from the framer to the cursor update
  typedef struct packed {
    logic  done;
    byte_t dx;
    byte_t dy;
    logic  left;
    logic  right;
  } pkt_t;

endpackage
`default_nettype wire

// ===== rtl/ps2_mouse_packet_cursor.sv =====
// ps2_mouse_packet_cursor
// Frames a stream of PS/2 mouse bytes into three-byte packets and moves a
// clamped cursor. Each accepted in_ item carries one received byte; a first
// byte without bit 3 set is dropped so framing recovers after a lost byte.
// The third byte of a packet produces one out_ item with the new cursor
// position and the left and right button bits; other bytes produce nothing.
// Pipeline: input register, then the framer and clamp logic, then the
// output register. out_tvalid rises as a packet's third byte leaves the
// input register. One item is accepted every cycle while out_ keeps up.
// When out_tready is low, the output register holds its item, the input
// register fills, and in_tready drops; nothing is lost or repeated.
// Reset is synchronous: limits and home return to 319, 239, 160, 120, framing
// restarts, and in_tready stays low after reset while the cursor loads from
// home. Writing a home register later does not move the cursor.
// cfg_ writes are always taken; write only while idle.
`default_nettype none
module ps2_mouse_packet_cursor (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [23:0] out_tdata, // [9:0] cursor_x, [19:10] cursor_y,
                                 // [20] left_button, [21] right_button, [23:22] zero
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [ps2mc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [ps2mc_pkg::COORD_W-1:0]   cfg_data
);
  import ps2mc_pkg::*;

  coord_t x_limit_r, y_limit_r, x_home_r, y_home_r;
  logic   loaded_r;
  logic   s1_valid_r;
  byte_t  s1_byte_r;
  logic   adv;
  pkt_t   pkt;
  coord_t pos_x_nxt, pos_y_nxt;
  logic   out_valid_r;
  coord_t out_x_r, out_y_r;
  logic   out_left_r, out_right_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RST;
      y_limit_r <= Y_LIMIT_RST;
      x_home_r  <= X_HOME_RST;
      y_home_r  <= Y_HOME_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_LIMIT: x_limit_r <= cfg_data;
        REG_Y_LIMIT: y_limit_r <= cfg_data;
        REG_X_HOME:  x_home_r  <= cfg_data;
        REG_Y_HOME:  y_home_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the input register when the output slot is free
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = loaded_r && (!s1_valid_r || adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      loaded_r <= 1'b1;
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
    end
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  ps2mc_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .rx_byte (s1_byte_r),
    .pkt     (pkt)
  );

  ps2mc_cursor u_cursor (
    .clk       (clk),
    .load_home (!loaded_r),
    .x_home    (x_home_r),
    .y_home    (y_home_r),
    .x_limit   (x_limit_r),
    .y_limit   (y_limit_r),
    .pkt       (pkt),
    .pos_x_nxt (pos_x_nxt),
    .pos_y_nxt (pos_y_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pkt.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (pkt.done) begin
      out_x_r     <= pos_x_nxt;
      out_y_r     <= pos_y_nxt;
      out_left_r  <= pkt.left;
      out_right_r <= pkt.right;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_right_r, out_left_r, out_y_r, out_x_r};

endmodule
`default_nettype wire

// ===== rtl/ps2mc_frame.sv =====
`default_nettype none
module ps2mc_frame (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             fire,
  input  ps2mc_pkg::byte_t rx_byte,
  output ps2mc_pkg::pkt_t pkt
);
  import ps2mc_pkg::*;

  typedef enum logic [1:0] {
    IDX_FIRST = 2'd0,
    IDX_DX    = 2'd1,
    IDX_DY    = 2'd2
  } idx_t;

  idx_t  idx_r, idx_nxt;
  byte_t status_r, status_nxt;
  byte_t dx_r, dx_nxt;

  always_comb begin
    idx_nxt    = idx_r;
    status_nxt = status_r;
    dx_nxt     = dx_r;
    pkt.done   = 1'b0;
    pkt.dx     = dx_r;
    pkt.dy     = rx_byte;
    pkt.left   = status_r[0];
    pkt.right  = status_r[1];
    case (idx_r)
      IDX_DX: begin
        dx_nxt  = rx_byte;
        idx_nxt = IDX_DY;
      end
      IDX_DY: begin
        pkt.done = fire;
        idx_nxt  = IDX_FIRST;
      end
      default: begin
        // drop a first byte without the sync bit to regain framing
        if (rx_byte[SYNC_BIT]) begin
          status_nxt = rx_byte;
          idx_nxt    = IDX_DX;
        end else begin
          idx_nxt = IDX_FIRST;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= IDX_FIRST;
    end else if (fire) begin
      idx_r <= idx_nxt;
    end
    if (fire) begin
      status_r <= status_nxt;
      dx_r     <= dx_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ps2mc_cursor.sv =====
`default_nettype none
module ps2mc_cursor (
  input  wire               clk,
  input  wire               load_home,
  input  ps2mc_pkg::coord_t x_home,
  input  ps2mc_pkg::coord_t y_home,
  input  ps2mc_pkg::coord_t x_limit,
  input  ps2mc_pkg::coord_t y_limit,
  input  ps2mc_pkg::pkt_t   pkt,
  output ps2mc_pkg::coord_t pos_x_nxt,
  output ps2mc_pkg::coord_t pos_y_nxt
);
  import ps2mc_pkg::*;

  localparam int unsigned SUM_W = COORD_W + 2;

  coord_t pos_x_r, pos_y_r;
  logic signed [SUM_W-1:0] sum_x, sum_y;

  function automatic coord_t clamp(input logic signed [SUM_W-1:0] v, input coord_t lim);
    coord_t res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({2'b00, lim})) begin
      res = lim;
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

  always_comb begin
    sum_x = $signed({2'b00, pos_x_r})
          + $signed({{(SUM_W-BYTE_W){pkt.dx[BYTE_W-1]}}, pkt.dx});
    sum_y = $signed({2'b00, pos_y_r})
          - $signed({{(SUM_W-BYTE_W){pkt.dy[BYTE_W-1]}}, pkt.dy});
    pos_x_nxt = clamp(sum_x, x_limit);
    pos_y_nxt = clamp(sum_y, y_limit);
  end

  always_ff @(posedge clk) begin
    if (load_home) begin
      pos_x_r <= x_home;
      pos_y_r <= y_home;
    end else if (pkt.done) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== verif/ps2mc_tb_pkg.sv =====
`timescale 1ns / 100ps
package ps2mc_tb_pkg;
  import ps2mc_pkg::*;

  // Where the next byte lands in the packet
  typedef enum logic [1:0] {
    SLOT_STATUS = 2'd0,
    SLOT_DX     = 2'd1,
    SLOT_DY     = 2'd2
  } pkt_slot_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   left;
    logic   right;
  } cursor_t;

  class cursor_scoreboard;
    coord_t    x_limit;
    coord_t    y_limit;
    coord_t    x_home;
    coord_t    y_home;
    pkt_slot_t slot;
    byte_t     status_b;
    byte_t     dx_b;
    coord_t    pos_x;
    coord_t    pos_y;
    cursor_t   expected_cursor_q[$];
    int unsigned errors;

    function new();
      x_limit  = X_LIMIT_RST;
      y_limit  = Y_LIMIT_RST;
      x_home   = X_HOME_RST;
      y_home   = Y_HOME_RST;
      slot     = SLOT_STATUS;
      status_b = '0;
      dx_b     = '0;
      pos_x    = x_home;
      pos_y    = y_home;
      errors   = 0;
    endfunction

    // Home registers only matter at reset; a later write leaves the cursor alone
    function void apply_write(logic [CFG_IDX_W-1:0] idx, coord_t val);
      case (idx)
        REG_X_LIMIT: x_limit = val;
        REG_Y_LIMIT: y_limit = val;
        REG_X_HOME:  x_home = val;
        REG_Y_HOME:  y_home = val;
        default: ;
      endcase
    endfunction

    static function coord_t clamp(int v, coord_t lim);
      if (v < 0) return '0;
      if (v > int'(lim)) return lim;
      return coord_t'(v);
    endfunction

    function int unsigned pending();
      return expected_cursor_q.size();
    endfunction

    function void note_byte(byte_t rx);
      cursor_t c;
      case (slot)
        SLOT_DX: begin
          dx_b = rx;
          slot = SLOT_DY;
        end
        SLOT_DY: begin
          pos_x   = clamp(int'(pos_x) + int'($signed(dx_b)), x_limit);
          pos_y   = clamp(int'(pos_y) - int'($signed(rx)), y_limit);
          c.x     = pos_x;
          c.y     = pos_y;
          c.left  = status_b[0];
          c.right = status_b[1];
          expected_cursor_q.push_back(c);
          slot = SLOT_STATUS;
        end
        default: begin
          // drop a first byte without the sync bit
          if (rx[SYNC_BIT]) begin
            status_b = rx;
            slot     = SLOT_DX;
          end else begin
            slot = SLOT_STATUS;
          end
        end
      endcase
    endfunction

    task check_result(logic [23:0] d);
      cursor_t got;
      cursor_t want;
      got.x     = d[9:0];
      got.y     = d[19:10];
      got.left  = d[20];
      got.right = d[21];
      if (expected_cursor_q.size() == 0) begin
        report($sformatf("item with no packet pending: x=%0d y=%0d", got.x, got.y));
        return;
      end
      want = expected_cursor_q.pop_front();
      if (got.x !== want.x)
        report($sformatf("cursor_x got %0d want %0d", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("cursor_y got %0d want %0d", got.y, want.y));
      if (got.left !== want.left)
        report($sformatf("left_button got %0b want %0b", got.left, want.left));
      if (got.right !== want.right)
        report($sformatf("right_button got %0b want %0b", got.right, want.right));
    endtask

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask
  endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import ps2mc_pkg::*;
  import ps2mc_tb_pkg::*;

  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned STALL_LIMIT     = 3000;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 110;

  // Indexes outside the register map; writes there are ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  byte_t                in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  coord_t               cfg_data   = '0;

  logic        hold_req       = 1'b0;
  int unsigned hold_cnt       = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  cursor_scoreboard sb = new();

  ps2_mouse_packet_cursor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: one long hold-off when requested, random stalls otherwise
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sample handshakes mid-cycle; signals are stable until the next rising edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (cfg_valid && cfg_ready) sb.apply_write(cfg_index, cfg_data);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Hold valid high across back-to-back items; lower it only while idling
  task automatic send_byte(input byte_t rx);
    logic taken;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    do begin
      @(negedge clk);
      taken = in_tvalid && in_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_packet(input byte_t st, input byte_t dx, input byte_t dy);
    send_byte(st);
    send_byte(dx);
    send_byte(dy);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t val);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_valid && cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every pending cursor item, then let dropped bytes flush through
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      IDLE_SEND: begin send_idle_pct = 49; recv_stall_pct <= 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct <= 49; end
      default:   begin send_idle_pct = 13; recv_stall_pct <= 13; end
    endcase
  endtask

  // Half full-range deltas, half small moves so the cursor wanders inside the limits
  function automatic byte_t rand_delta();
    if ($urandom_range(1) == 0) return byte_t'($urandom);
    return byte_t'(int'($urandom_range(16)) - 8);
  endfunction

  initial begin
    int unsigned sent;
    byte_t       st;
    byte_t       noise;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: sync-bit drops, delta extremes, clamps at both ends, button bits
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h08, 8'h7F, 8'h80);
    send_packet(8'h09, 8'h7F, 8'h80);
    send_packet(8'h0A, 8'h80, 8'h7F);
    send_packet(8'hFF, 8'h80, 8'h7F);
    send_packet(8'h0B, 8'h80, 8'h00);
    send_packet(8'hF8, 8'h00, 8'hFF);
    send_packet(8'h08, 8'h01, 8'h01);
    in_tvalid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(REG_X_LIMIT, 10'd1023);
          write_reg(REG_Y_LIMIT, 10'd1023);
          write_reg(REG_X_HOME, 10'd0);
          write_reg(REG_Y_HOME, 10'd1023);
        end
        1: begin
          write_reg(REG_X_LIMIT, 10'd0);
          write_reg(REG_Y_LIMIT, 10'd0);
          write_reg(REG_X_HOME, 10'd1023);
          write_reg(REG_Y_HOME, 10'd0);
          write_reg(REG_UNUSED_LO, 10'd5);
          write_reg(REG_UNUSED_HI, 10'd1023);
        end
        2: begin
          write_reg(REG_X_LIMIT, coord_t'($urandom));
          write_reg(REG_Y_LIMIT, coord_t'($urandom));
          write_reg(REG_X_HOME, coord_t'($urandom));
        end
        3: begin
          write_reg(REG_X_LIMIT, 10'd5);
          write_reg(REG_Y_LIMIT, 10'd1000);
        end
        4: begin
          write_reg(REG_X_LIMIT, 10'd1023);
          write_reg(REG_Y_LIMIT, 10'd0);
        end
        5: begin
          write_reg(REG_X_LIMIT, X_LIMIT_RST);
          write_reg(REG_Y_LIMIT, Y_LIMIT_RST);
          write_reg(REG_Y_HOME, coord_t'($urandom));
        end
        default: begin
          write_reg(REG_X_LIMIT, coord_t'($urandom_range(1023)));
          write_reg(REG_Y_LIMIT, coord_t'($urandom_range(1023)));
        end
      endcase
      set_mode(idle_mode_t'(ph % 4));
      if (ph == 0) hold_req <= 1'b1;

      // A still packet first: clamps a cursor left beyond a lowered limit
      send_packet(8'h08, 8'h00, 8'h00);
      sent = 3;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 85) begin
          st           = byte_t'($urandom);
          st[SYNC_BIT] = 1'b1;
          send_packet(st, rand_delta(), rand_delta());
          sent += 3;
        end else begin
          // stray byte: dropped, or it breaks framing of what follows
          noise = byte_t'($urandom);
          send_byte(noise);
          if (noise[SYNC_BIT]) sent++;
        end
      end
      in_tvalid <= 1'b0;
    end

    wait_idle();
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ps2mc_pkg.sv
rtl/ps2mc_frame.sv
rtl/ps2mc_cursor.sv
rtl/ps2_mouse_packet_cursor.sv
verif/ps2mc_tb_pkg.sv
verif/tb_top.sv
